/* hdl/assert_macros.svh */
// Assertion macros shared by the 3x3 box filter RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define BF3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// The condition must never be seen at a clock edge outside of reset.
`define BF3_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* hdl/bf3_pkg.sv */
// Shared types, constants and helpers for the 3x3 RGB box filter.
// Used by every filter module but the line store; depends on nothing else.
package bf3_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MIN_SIZE       = 3;

  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 3;
  localparam int PIX_W     = CHAN_W * NCHAN;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 11;

  // floor(255/9) = 28 fits in 5 bits; three of them per column fit in 7.
  localparam int Q_W    = 5;
  localparam int QSUM_W = 7;

  // Up to three results leave the window stage for one input pixel.
  localparam int MAX_RES = 3;
  localparam int PCNT_W  = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH = 16;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Channel k of a pixel sits at bits [8k+7:8k]: blue, green, red.
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    blue_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    red_out;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 frame_end;
  } pix_out_t;

  // Position flags of a pixel, worked out when it is accepted.
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_row;
    logic end_row;
  } ctl_t;

  // floor(p/9) for an 8-bit value: (p*57) >> 9 is exact for p below 511.
  function automatic logic [Q_W-1:0] div9(input logic [CHAN_W-1:0] p);
    logic [13:0] prod;
    prod = 14'(p) * 14'd57;
    return prod[13:9];
  endfunction

endpackage

/* hdl/bf3_line_mem.sv */
// Line store memory: one write port, one read port, registered read data.
// Holds the two previous rows side by side in each entry; no package use.
module bf3_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/bf3_window.sv */
// Window stage of the box filter: column quotient sums, window shift and
// result assembly. Depends on bf3_pkg.
module bf3_window #(
  parameter int ROW_W = $clog2(bf3_pkg::MAX_HEIGHT_DEF),
  parameter int COL_W = $clog2(bf3_pkg::MAX_WIDTH_DEF)
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         s1_valid,
  input  bf3_pkg::ctl_t                                s1_ctl,
  input  logic [ROW_W-1:0]                             s1_row,
  input  logic [COL_W-1:0]                             s1_col,
  input  bf3_pkg::pix_t                                s1_px,
  input  logic [2*bf3_pkg::PIX_W-1:0]                  line_rd,
  output logic                                         s2_valid,
  output logic [bf3_pkg::MAX_RES-1:0]                  res_valid,
  output bf3_pkg::pix_out_t [bf3_pkg::MAX_RES-1:0]     res
);

  import bf3_pkg::*;

  typedef logic [NCHAN-1:0][QSUM_W-1:0] qcol_t;

  pix_t             up;
  pix_t             lo;
  qcol_t            qcol;
  qcol_t            colsum_r [3];
  pix_t             mid_r [2];
  logic             s2_valid_r;
  ctl_t             s2_ctl_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  pix_t             s2_px_r;
  pix_t             mean;
  pix_t             centre;
  logic [OUT_ROW_W-1:0] row_above;
  logic [OUT_ROW_W-1:0] row_here;
  logic [OUT_COL_W-1:0] col_left;
  logic [OUT_COL_W-1:0] col_here;

  function automatic pix_out_t pack_out(input pix_t p, input logic [OUT_ROW_W-1:0] r,
                                        input logic [OUT_COL_W-1:0] c, input logic fe);
    pix_out_t o;
    o.blue_out  = p[CHAN_W-1:0];
    o.green_out = p[2*CHAN_W-1:CHAN_W];
    o.red_out   = p[3*CHAN_W-1:2*CHAN_W];
    o.out_row   = r;
    o.out_col   = c;
    o.frame_end = fe;
    return o;
  endfunction

  // Upper half of a line store entry is two rows up, lower half one row up.
  assign up = line_rd[2*PIX_W-1:PIX_W];
  assign lo = line_rd[PIX_W-1:0];

  // The new window column is reduced to one quotient sum per channel, so
  // the mean later needs only three narrow adds.
  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      qcol[k] = QSUM_W'(div9(up[k*CHAN_W +: CHAN_W]))
              + QSUM_W'(div9(lo[k*CHAN_W +: CHAN_W]))
              + QSUM_W'(div9(s1_px[k*CHAN_W +: CHAN_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      colsum_r[0] <= colsum_r[1];
      colsum_r[1] <= colsum_r[2];
      colsum_r[2] <= qcol;
      mid_r[0]    <= mid_r[1];
      mid_r[1]    <= lo;
      s2_ctl_r    <= s1_ctl;
      s2_row_r    <= s1_row;
      s2_col_r    <= s1_col;
      s2_px_r     <= s1_px;
    end
  end

  // Three sums of at most 84 stay at or below 252, so no clamp is needed.
  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      mean[k*CHAN_W +: CHAN_W] = CHAN_W'(colsum_r[0][k]) + CHAN_W'(colsum_r[1][k])
                               + CHAN_W'(colsum_r[2][k]);
    end
  end

  // Pixels of the first row or column of the frame pass through unchanged.
  assign centre = (s2_ctl_r.row_ge2 && s2_ctl_r.col_ge2) ? mean : mid_r[0];

  assign row_above = OUT_ROW_W'(s2_row_r - ROW_W'(1));
  assign row_here  = OUT_ROW_W'(s2_row_r);
  assign col_left  = OUT_COL_W'(s2_col_r - COL_W'(1));
  assign col_here  = OUT_COL_W'(s2_col_r);

  assign s2_valid = s2_valid_r;

  assign res_valid[0] = s2_valid_r && s2_ctl_r.row_ge1 && s2_ctl_r.col_ge1;
  assign res_valid[1] = s2_valid_r && s2_ctl_r.row_ge1 && s2_ctl_r.end_row;
  assign res_valid[2] = s2_valid_r && s2_ctl_r.last_row;

  assign res[0] = pack_out(centre, row_above, col_left, 1'b0);
  assign res[1] = pack_out(mid_r[1], row_above, col_here, 1'b0);
  assign res[2] = pack_out(s2_px_r, row_here, col_here, s2_ctl_r.end_row);

endmodule

/* hdl/bf3_out_queue.sv */
// Result queue: takes up to three results a cycle, hands out one a transfer.
// Depends on bf3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bf3_out_queue (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [bf3_pkg::MAX_RES-1:0]              push_valid,
  input  bf3_pkg::pix_out_t [bf3_pkg::MAX_RES-1:0] push_data,
  output logic [bf3_pkg::QCNT_W-1:0]               count,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output bf3_pkg::pix_out_t                        out_data
);

  import bf3_pkg::*;

  localparam int AW = $clog2(Q_DEPTH);

  pix_out_t           entry_r [Q_DEPTH];
  logic [AW-1:0]      head_r;
  logic [AW-1:0]      tail_r;
  logic [QCNT_W-1:0]  count_r;
  logic [AW-1:0]      slot [MAX_RES];
  logic [PCNT_W-1:0]  push_cnt;
  logic               pop;

  // Valid results are packed behind the tail in their original order.
  always_comb begin
    push_cnt = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      slot[k]  = tail_r + AW'(push_cnt);
      push_cnt = push_cnt + PCNT_W'(push_valid[k]);
    end
  end

  assign pop = (count_r != '0) && !out_stall;

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (push_valid[k]) begin
        entry_r[slot[k]] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + AW'(push_cnt);
      count_r <= count_r + QCNT_W'(push_cnt) - QCNT_W'(pop);
      if (pop) begin
        head_r <= head_r + AW'(1);
      end
    end
  end

  assign count     = count_r;
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[head_r];

  `BF3_ASSERT(a_queue_bound, count_r <= QCNT_W'(Q_DEPTH), "result queue overflow")
  `BF3_ASSERT(a_queue_idle, (count_r == '0 && push_cnt == '0) |=> (count_r == '0), "result queue grew without a push")

endmodule

/* hdl/box_filter_3x3_rgb.sv */
// 3x3 RGB box filter over a raster stream; uses bf3_pkg and assert_macros.svh.
// The result for pixel (r-1,c-1) passes stage 1, stage 2 and the queue once (r,c) is taken.
// Throughput: one pixel per clock while in_stall is low, set by one line store read and
// one write per pixel on separate ports; in the last row up to three results per pixel
// share the one output port.
// Reset (rst_n, synchronous): counters, pipeline and queue clear, size becomes 640x480;
// the line stores are not cleared and need no clearing pass.
`include "assert_macros.svh"

module box_filter_3x3_rgb #(
  parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bf3_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Pixel input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  bf3_pkg::pix_in_t  in_data,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output bf3_pkg::pix_out_t out_data,
  // Register port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  import bf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LINE_W = 2 * PIX_W;
  localparam int NEED_W = $clog2(Q_DEPTH + 3 * MAX_RES + 1);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // ---------------------------------------------------------------------
  // Register port. pready is tied high, so every access is one transfer.
  // Registers sit at byte addresses 0 (width) and 4 (height).
  // ---------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  frame_width_r;
  logic [CFG_HEIGHT_W-1:0] frame_height_r;
  logic                    cfg_wr;
  logic                    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_WIDTH_W'(WIDTH_RESET);
      frame_height_r <= CFG_HEIGHT_W'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_HEIGHT_W-1:0];
        default:          frame_width_r  <= frame_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Effective frame size. The programmed size is saturated to the range
  // 3..MAX, and held as the index of the last column and the last row.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (frame_width_r < CFG_WIDTH_W'(MIN_SIZE)) begin
      col_last = COL_W'(MIN_SIZE - 1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(frame_width_r - CFG_WIDTH_W'(1));
    end
  end

  always_comb begin
    if (frame_height_r < CFG_HEIGHT_W'(MIN_SIZE)) begin
      row_last = ROW_W'(MIN_SIZE - 1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(frame_height_r - CFG_HEIGHT_W'(1));
    end
  end

  // ---------------------------------------------------------------------
  // Raster position. A count left beyond a smaller frame size (after a
  // resize) starts over at zero. The counters advance on each transfer.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_count_r;
  logic [ROW_W-1:0] row_count_r;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             in_xfer;
  ctl_t             ctl_cur;

  assign in_xfer = in_valid && !in_stall;
  assign col_cur = (col_count_r > col_last) ? '0 : col_count_r;
  assign row_cur = (row_count_r > row_last) ? '0 : row_count_r;

  assign ctl_cur.row_ge1  = (row_cur != '0);
  assign ctl_cur.row_ge2  = (row_cur >= ROW_W'(2));
  assign ctl_cur.col_ge1  = (col_cur != '0);
  assign ctl_cur.col_ge2  = (col_cur >= COL_W'(2));
  assign ctl_cur.last_row = (row_cur == row_last);
  assign ctl_cur.end_row  = (col_cur == col_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_xfer) begin
      if (ctl_cur.end_row) begin
        col_count_r <= '0;
        row_count_r <= ctl_cur.last_row ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_count_r <= col_cur + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1. The line store entry of the current column is read on the
  // transfer edge and arrives together with the pixel in stage 1. It is then
  // written back shifted by one row: the old lower row moves up and the
  // new pixel becomes the lower row. The same column comes back no sooner
  // than three pixels later, so the write always lands before that read.
  // ---------------------------------------------------------------------
  logic             s1_valid_r;
  ctl_t             s1_ctl_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_px_r;
  logic [LINE_W-1:0] line_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ctl_r <= ctl_cur;
      s1_row_r <= row_cur;
      s1_col_r <= col_cur;
      s1_px_r  <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
  end

  bf3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (LINE_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_cur),
    .rd_data (line_rd),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data ({line_rd[PIX_W-1:0], s1_px_r})
  );

  // ---------------------------------------------------------------------
  // Stage 2. The window unit shifts in the new column and builds up to
  // three results: the centre pixel one row and one column back, the end
  // of the row above when a row ends, and the pixel itself in the last row.
  // ---------------------------------------------------------------------
  logic                      s2_valid;
  logic [MAX_RES-1:0]        res_valid;
  pix_out_t [MAX_RES-1:0]    res;
  logic [QCNT_W-1:0]         q_count;
  logic [NEED_W-1:0]         q_need;

  bf3_window #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_ctl    (s1_ctl_r),
    .s1_row    (s1_row_r),
    .s1_col    (s1_col_r),
    .s1_px     (s1_px_r),
    .line_rd   (line_rd),
    .s2_valid  (s2_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  // ---------------------------------------------------------------------
  // Result queue. Input transfers are held off unless the queue has room
  // for the worst case of every pixel still in the pipeline plus one more,
  // so the pipeline itself never has to stop.
  // ---------------------------------------------------------------------
  bf3_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .count      (q_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign q_need = NEED_W'(q_count)
                + (s1_valid_r ? NEED_W'(MAX_RES) : '0)
                + (s2_valid ? NEED_W'(MAX_RES) : '0)
                + NEED_W'(MAX_RES);
  assign in_stall = (q_need > NEED_W'(Q_DEPTH));

  `BF3_ASSERT(a_stage_order, s2_valid |-> $past(s1_valid_r), "window stage ran without stage 1")
  `BF3_NEVER(a_line_hazard, in_xfer && s1_valid_r && (col_cur == s1_col_r), "line column hazard")

endmodule

/* tb/tb_box_filter_3x3_rgb.sv */
// Self-checking testbench for box_filter_3x3_rgb: pixel stream, result stream, register port.
// Depends on bf3_pkg for the pixel and result structs and the size constants.
`timescale 1ns / 1ps

module tb_box_filter_3x3_rgb;
  import bf3_pkg::*;

  // Register map: width at byte 0, height at byte 4.
  localparam logic [2:0]  ADDR_WIDTH    = 3'd0;
  localparam logic [2:0]  ADDR_HEIGHT   = 3'd4;
  localparam logic [31:0] WIDTH_MASK    = 32'h0000_0FFF;
  localparam logic [31:0] HEIGHT_MASK   = 32'h0000_1FFF;
  // Settling time after the last result, with ample margin for pixels still inside the block.
  localparam int          SETTLE_CYCLES = 16;
  localparam int          RANDOM_PIXELS = 60;
  // Widest frame the random rounds can program.
  localparam int          PREFILL_WIDTH = 16;

  typedef enum logic [1:0] {STEP_READ, STEP_WRITE, STEP_PIXEL, STEP_SETTLE} step_kind_t;

  // One row of the directed table. rd_want is only used by register reads.
  typedef struct {
    step_kind_t  kind;
    logic [2:0]  addr;
    logic [31:0] data;
    logic [31:0] rd_want;
  } step_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  pix_in_t     in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  pix_out_t    out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  box_filter_3x3_rgb i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #30_000_000;
    $display("tb_box_filter_3x3_rgb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor. It keeps its own copy of the size registers, the two row
  // buffers, the 3x3 neighborhood and the raster position, and turns every
  // accepted pixel into the zero to three results that pixel releases.
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  width_reg  = CFG_WIDTH_W'(WIDTH_RESET);
  logic [CFG_HEIGHT_W-1:0] height_reg = CFG_HEIGHT_W'(HEIGHT_RESET);
  pix_t                    upper_line [MAX_WIDTH_DEF];
  pix_t                    lower_line [MAX_WIDTH_DEF];
  pix_t                    nbhd [3][3] = '{default: '0};
  int unsigned             row_pos = 0;
  int unsigned             col_pos = 0;

  pix_out_t pending_results [$];
  int       error_count = 0;
  // When set, neither side inserts idle cycles.
  bit       quiet = 1'b0;

  // Sizes outside the legal range are clamped, not rejected.
  function automatic int unsigned eff_width();
    if (width_reg < MIN_SIZE) return MIN_SIZE;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < MIN_SIZE) return MIN_SIZE;
    if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return 32'(height_reg);
  endfunction

  // Each channel is the sum of the nine truncated ninths. The sum tops out at
  // 252, so the saturation below should never take effect.
  function automatic pix_t box_mean();
    int unsigned sum;
    pix_t        res;
    res = '0;
    for (int k = 0; k < NCHAN; k++) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum += nbhd[i][j][CHAN_W*k +: CHAN_W] / 9;
        end
      end
      if (sum > 255) sum = 255;
      res[CHAN_W*k +: CHAN_W] = sum[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic pix_out_t make_result(pix_t v, int unsigned r, int unsigned c,
                                           logic fe);
    pix_out_t o;
    o.blue_out  = v[7:0];
    o.green_out = v[15:8];
    o.red_out   = v[23:16];
    o.out_row   = r[OUT_ROW_W-1:0];
    o.out_col   = c[OUT_COL_W-1:0];
    o.frame_end = fe;
    return o;
  endfunction

  task automatic filter_pixel(input pix_in_t p);
    int unsigned w, h, r, c;
    pix_t        px, up, lo;
    logic        last_row, end_row;
    w = eff_width();
    h = eff_height();
    // A resize can leave the position outside the new frame; it then restarts.
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r  = row_pos;
    c  = col_pos;
    px = {p.red_in, p.green_in, p.blue_in};

    up = upper_line[c];
    lo = lower_line[c];
    upper_line[c] = lo;
    lower_line[c] = px;

    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = lo;
    nbhd[2][2] = px;

    last_row = (r == h - 1);
    end_row  = (c == w - 1);

    // The row above is released one pixel behind; its last pixel follows at
    // the end of the current row. Only interior pixels are averaged.
    if (r >= 1) begin
      if (c >= 1) begin
        pending_results.push_back(make_result((r >= 2 && c >= 2) ? box_mean() : nbhd[1][1],
                                              r - 1, c - 1, 1'b0));
      end
      if (end_row) pending_results.push_back(make_result(nbhd[1][2], r - 1, w - 1, 1'b0));
    end
    // Bottom-row pixels have no row below, so they go out right away.
    if (last_row) pending_results.push_back(make_result(px, r, c, end_row));

    if (end_row) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input pix_out_t got);
    pix_out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", got, '0);
    end else begin
      want = pending_results.pop_front();
      if (got.blue_out !== want.blue_out) report_mismatch("blue_out", 48'(got.blue_out),
                                                          48'(want.blue_out));
      if (got.green_out !== want.green_out) report_mismatch("green_out", 48'(got.green_out),
                                                            48'(want.green_out));
      if (got.red_out !== want.red_out) report_mismatch("red_out", 48'(got.red_out),
                                                        48'(want.red_out));
      if (got.out_row !== want.out_row) report_mismatch("out_row", 48'(got.out_row),
                                                        48'(want.out_row));
      if (got.out_col !== want.out_col) report_mismatch("out_col", 48'(got.out_col),
                                                        48'(want.out_col));
      if (got.frame_end !== want.frame_end) report_mismatch("frame_end", 48'(got.frame_end),
                                                            48'(want.frame_end));
    end
  endtask

  // Both channels are watched from one process so that a pixel's results are
  // always queued before anything that could match them is checked. Signals
  // are read at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) filter_pixel(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Mostly random colors, with some saturated white pixels so that the
  // neighborhood sums reach their top.
  function automatic pix_in_t random_pixel();
    logic [PIX_W-1:0] bits;
    bits = PIX_W'($urandom());
    if ($urandom_range(0, 7) == 0) bits = '1;
    return bits;
  endfunction

  // Idle for a random number of cycles, then hold the pixel until it transfers.
  task automatic send_pixel(input pix_in_t p);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every queued result has arrived. The extra
  // cycles cover pixels still inside the block that release no result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // Only the low bits of each register exist; the rest of the word is dropped.
    if (addr == ADDR_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
    else height_reg = value[CFG_HEIGHT_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [2:0] addr, input logic [31:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) report_mismatch("register readback", 48'(cfg_prdata), 48'(want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result-side back-pressure: stall for a random count before every transfer.
  initial begin
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = draw_gap();
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    step_t       script [$];
    int unsigned w, h, n_pix, sent, round;
    logic [31:0] w_field, h_field;

    // Directed table. Register reads carry their expected value; the pixel
    // rows form one complete 3x3 frame (one interior pixel, eight border
    // pixels) and are checked by the predictor.
    script.push_back('{STEP_READ,  ADDR_WIDTH,  32'h0, 32'(WIDTH_RESET)});
    script.push_back('{STEP_READ,  ADDR_HEIGHT, 32'h0, 32'(HEIGHT_RESET)});
    // Zero width with junk in the unused upper bits: clamps to three.
    script.push_back('{STEP_WRITE, ADDR_WIDTH,  32'hFFFF_F000, 32'h0});
    // Height of one with junk above bit 12: clamps to three.
    script.push_back('{STEP_WRITE, ADDR_HEIGHT, 32'hAAAA_E001, 32'h0});
    script.push_back('{STEP_READ,  ADDR_WIDTH,  32'h0, 32'h0000_0000});
    script.push_back('{STEP_READ,  ADDR_HEIGHT, 32'h0, 32'h0000_0001});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h00FF_FFFF, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h0000_0000, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h00FF_00FF, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h0000_FF00, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h00FF_FFFF, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h0012_3456, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h00FE_DCBA, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h000F_0F0F, 32'h0});
    script.push_back('{STEP_PIXEL, ADDR_WIDTH,  32'h00F0_F0F0, 32'h0});
    script.push_back('{STEP_SETTLE, ADDR_WIDTH, 32'h0, 32'h0});
    // All ones: only the twelve register bits read back.
    script.push_back('{STEP_WRITE, ADDR_WIDTH,  32'hFFFF_FFFF, 32'h0});
    script.push_back('{STEP_READ,  ADDR_WIDTH,  32'h0, 32'h0000_0FFF});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      unique case (script[i].kind)
        STEP_READ: begin
          reg_read(script[i].addr, script[i].rd_want);
        end
        STEP_WRITE: begin
          reg_write(script[i].addr, script[i].data);
        end
        STEP_PIXEL: begin
          send_pixel(script[i].data[PIX_W-1:0]);
        end
        default: begin
          drain();
        end
      endcase
    end

    // One full three-row frame at the widest size the random rounds use. It
    // fills every row-buffer entry they can reach, so later mid-frame width
    // increases never pull in unwritten data.
    reg_write(ADDR_WIDTH, ($urandom() & ~WIDTH_MASK) | 32'(PREFILL_WIDTH));
    reg_write(ADDR_HEIGHT, ($urandom() & ~HEIGHT_MASK) | 32'd3);
    repeat (3 * PREFILL_WIDTH) send_pixel(random_pixel());
    drain();

    // Random rounds of small frames. A round may stop anywhere in a frame, so
    // the next round's resize often lands mid-frame and forces the position
    // to restart. Round 1, if reached, uses an oversized height that clamps to
    // the maximum and never finishes its frame; round 2, if reached, shrinks to
    // the minimum width and pauses halfway until every outstanding result is back.
    sent  = 0;
    round = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w_field = $urandom_range(0, 2);
        1:       w_field = $urandom_range(9, PREFILL_WIDTH);
        default: w_field = $urandom_range(3, 6);
      endcase
      h_field = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      if (round == 1) h_field = HEIGHT_MASK;
      if (round == 2) w_field = MIN_SIZE;
      reg_write(ADDR_WIDTH, ($urandom() & ~WIDTH_MASK) | w_field);
      reg_write(ADDR_HEIGHT, ($urandom() & ~HEIGHT_MASK) | h_field);

      w     = eff_width();
      h     = eff_height();
      quiet = ($urandom_range(0, 3) == 0);
      if (round == 1) n_pix = 5 * w + $urandom_range(0, w - 1);
      else if (round == 2) n_pix = $urandom_range(2 * w, 2 * w * h);
      else n_pix = $urandom_range(2, 2 * w * h);

      for (int unsigned i = 0; i < n_pix; i++) begin
        if (round == 2 && i == n_pix / 2) drain();
        send_pixel(random_pixel());
      end
      sent += n_pix;
      drain();
      round++;
    end
    quiet = 1'b0;

    if (error_count == 0) begin
      $display("tb_box_filter_3x3_rgb: done, clean");
    end else begin
      $display("tb_box_filter_3x3_rgb: done, errors");
    end
    $finish;
  end

endmodule
